// ===== rtl/core/bclm_pkg.sv =====
// ----------------------------------------------------------------------------
// bclm_pkg
// Shared types and constants of the bounded circular list manager.
// ----------------------------------------------------------------------------
package bclm_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = 7;
  localparam int VAL_W    = 32;

  typedef enum logic [3:0] {
    OP_CLEAR    = 4'd0,
    OP_INS_HEAD = 4'd1,
    OP_INS_TAIL = 4'd2,
    OP_INS_POS  = 4'd3,
    OP_DEL_HEAD = 4'd4,
    OP_DEL_TAIL = 4'd5,
    OP_DEL_POS  = 4'd6,
    OP_REVERSE  = 4'd7,
    OP_LIST     = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EMIT, S_WALK,
    S_INS_A, S_INS_B,
    S_INS_P, S_INS_Q, S_INS_R, S_INS_S,
    S_DEL_H, S_DEL_P, S_DEL_Q, S_DEL_R,
    S_REL, S_REL_W,
    S_REV, S_LIST
  } state_t;

  typedef struct packed {
    logic [3:0]              op;
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element;
    logic [1:0]              status;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } out_item_t;

endpackage

// ===== rtl/core/bclm_ram.sv =====
// ----------------------------------------------------------------------------
// bclm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bclm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bounded_circular_list_manager_top.sv =====
// ----------------------------------------------------------------------------
// bounded_circular_list_manager_top
// Circular singly linked list of up to CAPACITY values with a free list.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; in_ready is high only while idle.
// Positional inserts, positional and tail deletes walk the link memory one
// node per cycle. The walk is bounded by the single read port of the link
// memory. Node links come out of reset (and clear) as a chain through valid
// bits, so there is no clearing pass.
module bounded_circular_list_manager_top
  import bclm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [IDX_W-1:0] first_r, first_nxt, final_r, final_nxt, free_r, free_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt, node_r, node_nxt;
  logic [LEN_W-1:0] count_r, count_nxt, steps_r, steps_nxt;
  logic [CAPACITY-1:0] lv_r, lv_nxt;
  logic [3:0]       op_r, op_nxt;
  logic [VAL_W-1:0] val_r, val_nxt, elem_r, elem_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             l_we, l_re, v_we, v_re;
  logic [IDX_W-1:0] l_wa, l_ra, v_wa, v_ra, l_ra_r, l_q, lnk_rd;
  logic [IDX_W-1:0] l_wd;
  logic [VAL_W-1:0] v_wd, v_q;

  bclm_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd),
    .re(l_re), .raddr(l_ra), .rdata(l_q)
  );

  bclm_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_value (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
    .re(v_re), .raddr(v_ra), .rdata(v_q)
  );

  // never-written links read as the reset chain
  assign lnk_rd = lv_r[l_ra_r] ? l_q :
                  (l_ra_r == IDX_W'(CAPACITY - 1)) ? '0 : l_ra_r + IDX_W'(1);

  logic             full, empty, slot_free;
  logic [3:0]       eop;
  logic [LEN_W-1:0] pos, dpos;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign full      = count_r >= LEN_W'(CAPACITY);
  assign empty     = count_r == '0;
  assign slot_free = !out_valid_r || out_ready;
  assign pos       = in_data.position;

  always_comb begin
    eop = in_data.op;
    if (in_data.op == OP_INS_POS && pos == LEN_W'(1) && !empty) begin
      eop = OP_INS_HEAD;
    end
    if (in_data.op == OP_DEL_POS && pos == LEN_W'(1) && !empty) begin
      eop = OP_DEL_HEAD;
    end
    dpos = (eop == OP_DEL_TAIL) ? count_r : pos;
  end

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r;
    first_nxt = first_r; final_nxt = final_r; free_nxt = free_r;
    cur_nxt = cur_r; node_nxt = node_r; count_nxt = count_r; steps_nxt = steps_r;
    lv_nxt = lv_r; op_nxt = op_r; val_nxt = val_r; elem_nxt = elem_r; st_nxt = st_r;
    out_valid_nxt = out_valid_r && !out_ready; out_nxt = out_r;
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_re = 1'b0; l_ra = '0;
    v_we = 1'b0; v_wa = '0; v_wd = '0; v_re = 1'b0; v_ra = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = eop; val_nxt = in_data.value;
          elem_nxt = '0; st_nxt = ST_OK;
          state_nxt = S_EMIT;
          case (eop) inside
            OP_CLEAR: begin
              lv_nxt = '0; first_nxt = '0; final_nxt = '0;
              free_nxt = '0; count_nxt = '0;
            end
            OP_INS_HEAD, OP_INS_TAIL: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                l_re = 1'b1; l_ra = free_r; node_nxt = free_r;
                v_we = 1'b1; v_wa = free_r; v_wd = in_data.value;
                state_nxt = S_INS_A;
              end
            end
            OP_INS_POS: begin
              if (pos < LEN_W'(1) || pos > count_r) begin
                st_nxt = ST_INVALID;
              end else if (full) begin
                st_nxt = ST_FULL;
              end else begin
                cur_nxt = first_r; ret_nxt = S_INS_P;
                steps_nxt = pos - LEN_W'(2);
                if (pos == LEN_W'(2)) begin
                  state_nxt = S_INS_P;
                end else begin
                  l_re = 1'b1; l_ra = first_r; state_nxt = S_WALK;
                end
              end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
              if (empty) begin
                st_nxt = ST_EMPTY;
              end else if (eop == OP_DEL_POS && (pos < LEN_W'(1) || pos > count_r)) begin
                st_nxt = ST_INVALID;
              end else if (count_r == LEN_W'(1)) begin
                node_nxt = first_r; first_nxt = '0; final_nxt = '0;
                state_nxt = S_REL;
              end else if (eop == OP_DEL_HEAD) begin
                node_nxt = first_r; l_re = 1'b1; l_ra = first_r;
                state_nxt = S_DEL_H;
              end else begin
                cur_nxt = first_r; ret_nxt = S_DEL_P;
                steps_nxt = dpos - LEN_W'(2);
                if (dpos == LEN_W'(2)) begin
                  state_nxt = S_DEL_P;
                end else begin
                  l_re = 1'b1; l_ra = first_r; state_nxt = S_WALK;
                end
              end
            end
            OP_REVERSE: begin
              if (empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                node_nxt = final_r; cur_nxt = first_r; steps_nxt = count_r;
                l_re = 1'b1; l_ra = first_r; state_nxt = S_REV;
              end
            end
            OP_LIST: begin
              if (empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                steps_nxt = count_r;
                l_re = 1'b1; l_ra = first_r; v_re = 1'b1; v_ra = first_r;
                state_nxt = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        cur_nxt = lnk_rd;
        if (steps_r == LEN_W'(1)) begin
          state_nxt = ret_r;
        end else begin
          l_re = 1'b1; l_ra = lnk_rd; steps_nxt = steps_r - LEN_W'(1);
        end
      end
      S_INS_A: begin
        free_nxt = lnk_rd; l_we = 1'b1; l_wa = node_r;
        if (empty) begin
          l_wd = node_r; first_nxt = node_r; final_nxt = node_r;
          count_nxt = count_r + LEN_W'(1); elem_nxt = val_r; state_nxt = S_EMIT;
        end else begin
          l_wd = first_r; state_nxt = S_INS_B;
        end
      end
      S_INS_B: begin
        l_we = 1'b1; l_wa = final_r; l_wd = node_r;
        if (op_r == OP_INS_HEAD) begin
          first_nxt = node_r;
        end else begin
          final_nxt = node_r;
        end
        count_nxt = count_r + LEN_W'(1); elem_nxt = val_r; state_nxt = S_EMIT;
      end
      S_INS_P: begin
        l_re = 1'b1; l_ra = free_r; node_nxt = free_r;
        v_we = 1'b1; v_wa = free_r; v_wd = val_r;
        state_nxt = S_INS_Q;
      end
      S_INS_Q: begin
        free_nxt = lnk_rd; l_re = 1'b1; l_ra = cur_r; state_nxt = S_INS_R;
      end
      S_INS_R: begin
        l_we = 1'b1; l_wa = node_r; l_wd = lnk_rd; state_nxt = S_INS_S;
      end
      S_INS_S: begin
        l_we = 1'b1; l_wa = cur_r; l_wd = node_r;
        count_nxt = count_r + LEN_W'(1); elem_nxt = val_r; state_nxt = S_EMIT;
      end
      S_DEL_H: begin
        first_nxt = lnk_rd; l_we = 1'b1; l_wa = final_r; l_wd = lnk_rd;
        state_nxt = S_REL;
      end
      S_DEL_P: begin
        l_re = 1'b1; l_ra = cur_r; state_nxt = S_DEL_Q;
      end
      S_DEL_Q: begin
        node_nxt = lnk_rd; l_re = 1'b1; l_ra = lnk_rd; state_nxt = S_DEL_R;
      end
      S_DEL_R: begin
        l_we = 1'b1; l_wa = cur_r; l_wd = lnk_rd;
        if (node_r == final_r) begin
          final_nxt = cur_r;
        end
        state_nxt = S_REL;
      end
      S_REL: begin
        v_re = 1'b1; v_ra = node_r; state_nxt = S_REL_W;
      end
      S_REL_W: begin
        // return node to the free list
        l_we = 1'b1; l_wa = node_r; l_wd = free_r; free_nxt = node_r;
        count_nxt = count_r - LEN_W'(1); elem_nxt = v_q; state_nxt = S_EMIT;
      end
      S_REV: begin
        l_we = 1'b1; l_wa = cur_r; l_wd = node_r;
        node_nxt = cur_r; cur_nxt = lnk_rd;
        if (steps_r == LEN_W'(1)) begin
          first_nxt = final_r; final_nxt = first_r; state_nxt = S_EMIT;
        end else begin
          l_re = 1'b1; l_ra = lnk_rd; steps_nxt = steps_r - LEN_W'(1);
        end
      end
      S_LIST: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.element = v_q; out_nxt.status = ST_OK;
          out_nxt.length = count_r; out_nxt.last = (steps_r == LEN_W'(1));
          if (steps_r == LEN_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            l_re = 1'b1; l_ra = lnk_rd; v_re = 1'b1; v_ra = lnk_rd;
            steps_nxt = steps_r - LEN_W'(1);
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.element = elem_r; out_nxt.status = st_r;
          out_nxt.length = count_r; out_nxt.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (l_we) begin
      lv_nxt[l_wa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ret_r <= S_IDLE;
      first_r <= '0; final_r <= '0; free_r <= '0; count_r <= '0;
      lv_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ret_r <= ret_nxt;
      first_r <= first_nxt; final_r <= final_nxt; free_r <= free_nxt;
      count_r <= count_nxt; lv_r <= lv_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; node_r <= node_nxt; steps_r <= steps_nxt;
    op_r <= op_nxt; val_r <= val_nxt; elem_r <= elem_nxt; st_r <= st_nxt;
    out_r <= out_nxt;
    if (l_re) begin
      l_ra_r <= l_ra;
    end
  end

endmodule

// ===== rtl/core/bclm_checker.sv =====
// ----------------------------------------------------------------------------
// bclm_checker
// Port-level checks of the list manager, bound to the top level.
// ----------------------------------------------------------------------------
module bclm_checker
  import bclm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.length <= LEN_W'(CAPACITY))
    else $error("length beyond capacity");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.element == '0 && out_data.last)
    else $error("error result not single or not zero");

endmodule

bind bounded_circular_list_manager_top bclm_checker u_bclm_checker (.*);
